@@ design/pfx_eval_pkg.sv @@
// ----------------------------------------------------------------------------
// pfx_eval_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_eval_pkg;

  localparam int WORD_W   = 32;
  localparam int SYM_W    = 8;
  localparam int LIMIT_W  = 5;
  localparam int DIV_CNT_W = $clog2(WORD_W + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  localparam logic [SYM_W-1:0] CHAR_0   = 8'd48;
  localparam logic [SYM_W-1:0] CHAR_9   = 8'd57;
  localparam logic [SYM_W-1:0] CHAR_MUL = 8'd42;
  localparam logic [SYM_W-1:0] CHAR_DIV = 8'd47;
  localparam logic [SYM_W-1:0] CHAR_ADD = 8'd43;
  localparam logic [SYM_W-1:0] CHAR_SUB = 8'd45;
  localparam logic [SYM_W-1:0] CHAR_MOD = 8'd37;

  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd999;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     overflow_seen;
    logic                     underflow_seen;
    logic                     divide_by_zero_seen;
  } out_beat_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] dividend;
    logic signed [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] quot;
    logic signed [WORD_W-1:0] rem;
  } div_rsp_t;

endpackage

@@ design/pfx_eval_div.sv @@
// ----------------------------------------------------------------------------
// pfx_eval_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfx_eval_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pfx_eval_pkg::div_req_t req,
  output pfx_eval_pkg::div_rsp_t rsp
);
  import pfx_eval_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WORD_W-1:0]    quo_r, quo_nxt;
  logic [WORD_W-1:0]    rem_r, rem_nxt;
  logic [WORD_W-1:0]    dvs_r, dvs_nxt;
  logic                 q_neg_r, q_neg_nxt;
  logic                 r_neg_r, r_neg_nxt;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      diff;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    q_neg_nxt = q_neg_r;
    r_neg_nxt = r_neg_r;
    rem_sh    = {rem_r, quo_r[WORD_W-1]};
    diff      = rem_sh - {1'b0, dvs_r};
    if (req.start) begin
      // magnitudes fit unsigned, the most negative value included
      busy_nxt  = 1'b1;
      cnt_nxt   = DIV_CNT_W'(WORD_W);
      quo_nxt   = req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
      dvs_nxt   = req.divisor[WORD_W-1] ? -req.divisor : req.divisor;
      rem_nxt   = '0;
      q_neg_nxt = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
      r_neg_nxt = req.dividend[WORD_W-1];
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        if (!diff[WORD_W]) begin
          rem_nxt = diff[WORD_W-1:0];
          quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[WORD_W-1:0];
          quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    q_neg_r <= q_neg_nxt;
    r_neg_r <= r_neg_nxt;
  end

  assign rsp.done = busy_r && (cnt_r == '0);
  assign rsp.quot = q_neg_r ? -quo_r : quo_r;
  assign rsp.rem  = r_neg_r ? -rem_r : rem_r;

endmodule

@@ design/postfix_expression_evaluator.sv @@
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix evaluator over an operand stack kept in a synchronous memory.
// ----------------------------------------------------------------------------
//  port group   direction  payload     handshake
//  in_*         input      in_beat_t   in_valid / in_stall
//  out_*        output     out_beat_t  out_valid / out_stall
//  cfg_*        input      stack limit cfg_wr_en, no wait
//
//  a digit passes S_PUSH; + - * pass S_POP_R, S_POP_L, S_CALC and S_PUSH; / and %
//  also wait in S_DIV unless the divisor is zero; an ignored symbol stays in S_IDLE;
//  a last beat adds S_FIN_RD and S_FIN for the final stack read. The memory has one
//  registered read port, so the two pops and the push run one after another.
//  reset (rst_n low, synchronous) empties the stack, clears the flags and sets
//  the limit to 16. A result waits in the output register under out_stall;
//  input is taken meanwhile, only a second result waits for the first.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pfx_eval_pkg::in_beat_t             in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pfx_eval_pkg::out_beat_t            out_data,
  input  logic                               cfg_wr_en,
  input  logic [pfx_eval_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import pfx_eval_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_POP_R  = 4'd1;
  localparam logic [ST_W-1:0] S_POP_L  = 4'd2;
  localparam logic [ST_W-1:0] S_CALC   = 4'd3;
  localparam logic [ST_W-1:0] S_DIV    = 4'd4;
  localparam logic [ST_W-1:0] S_PUSH   = 4'd5;
  localparam logic [ST_W-1:0] S_FIN_RD = 4'd6;
  localparam logic [ST_W-1:0] S_FIN    = 4'd7;

  logic [ST_W-1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     ovf_r, ovf_nxt;
  logic                     unf_r, unf_nxt;
  logic                     dz_r, dz_nxt;
  logic [LIMIT_W-1:0]       limit_r;
  logic                     out_valid_r, out_valid_nxt;
  out_beat_t                out_data_r, out_data_nxt;

  logic [SYM_W-1:0]         sym_r, sym_nxt;
  logic                     last_r, last_nxt;
  logic                     rok_r, rok_nxt;
  logic                     lok_r, lok_nxt;
  logic signed [WORD_W-1:0] right_r, right_nxt;
  logic signed [WORD_W-1:0] res_r, res_nxt;
  logic signed [WORD_W-1:0] left_v;

  logic [WORD_W-1:0]        mem [STACK_DEPTH];
  logic signed [WORD_W-1:0] rd_data_r;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        top_addr;

  logic [CMP_W-1:0]         lim_ext;
  logic [CMP_W-1:0]         lim_eff;
  logic                     full;
  logic                     is_digit;
  logic                     is_op;

  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  pfx_eval_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // limit of 0 acts as 1, above the built depth acts as the depth
  always_comb begin
    lim_ext = CMP_W'(limit_r);
    if (lim_ext == '0) begin
      lim_eff = CMP_W'(1);
    end else if (lim_ext > CMP_W'(STACK_DEPTH)) begin
      lim_eff = CMP_W'(STACK_DEPTH);
    end else begin
      lim_eff = lim_ext;
    end
  end

  assign full     = (CMP_W'(count_r) >= lim_eff);
  assign top_addr = ADDR_W'(count_r - 1'b1);
  assign wr_addr  = count_r[ADDR_W-1:0];
  assign is_digit = (in_data.symbol >= CHAR_0) && (in_data.symbol <= CHAR_9);
  assign is_op    = (in_data.symbol == CHAR_MUL) || (in_data.symbol == CHAR_DIV) ||
                    (in_data.symbol == CHAR_ADD) || (in_data.symbol == CHAR_SUB) ||
                    (in_data.symbol == CHAR_MOD);
  assign left_v   = lok_r ? rd_data_r : EMPTY_WORD;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    unf_nxt       = unf_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sym_nxt       = sym_r;
    last_nxt      = last_r;
    rok_nxt       = rok_r;
    lok_nxt       = lok_r;
    right_nxt     = right_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = top_addr;
    wr_en         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = left_v;
    div_req.divisor  = right_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt  = in_data.symbol;
          last_nxt = in_data.last;
          if (is_digit) begin
            res_nxt   = WORD_W'(in_data.symbol - CHAR_0);
            state_nxt = S_PUSH;
          end else if (is_op) begin
            state_nxt = S_POP_R;
          end else begin
            state_nxt = in_data.last ? S_FIN_RD : S_IDLE;
          end
        end
      end
      S_POP_R: begin
        if (count_r != '0) begin
          rd_en     = 1'b1;
          count_nxt = count_r - 1'b1;
          rok_nxt   = 1'b1;
        end else begin
          unf_nxt = 1'b1;
          rok_nxt = 1'b0;
        end
        state_nxt = S_POP_L;
      end
      S_POP_L: begin
        right_nxt = rok_r ? rd_data_r : EMPTY_WORD;
        if (count_r != '0) begin
          rd_en     = 1'b1;
          count_nxt = count_r - 1'b1;
          lok_nxt   = 1'b1;
        end else begin
          unf_nxt = 1'b1;
          lok_nxt = 1'b0;
        end
        state_nxt = S_CALC;
      end
      S_CALC: begin
        state_nxt = S_PUSH;
        case (sym_r)
          CHAR_ADD: res_nxt = left_v + right_r;
          CHAR_SUB: res_nxt = left_v - right_r;
          CHAR_MUL: res_nxt = left_v * right_r;
          default: begin
            if (right_r == '0) begin
              dz_nxt  = 1'b1;
              res_nxt = '0;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_nxt   = (sym_r == CHAR_MOD) ? div_rsp.rem : div_rsp.quot;
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
        state_nxt = last_r ? S_FIN_RD : S_IDLE;
      end
      S_FIN_RD: begin
        // a push in the previous cycle is already in the array here
        if (count_r != '0) begin
          rd_en   = 1'b1;
          rok_nxt = 1'b1;
        end else begin
          rok_nxt = 1'b0;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                    = 1'b1;
          out_data_nxt.value               = rok_r ? rd_data_r : EMPTY_WORD;
          out_data_nxt.overflow_seen       = ovf_r;
          out_data_nxt.underflow_seen      = unf_r | ~rok_r;
          out_data_nxt.divide_by_zero_seen = dz_r;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          unf_nxt   = 1'b0;
          dz_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      unf_r       <= 1'b0;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      unf_r       <= unf_nxt;
      dz_r        <= dz_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    sym_r      <= sym_nxt;
    last_r     <= last_nxt;
    rok_r      <= rok_nxt;
    lok_r      <= lok_nxt;
    right_r    <= right_nxt;
    res_r      <= res_nxt;
  end

  // operand stack, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= res_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the postfix expression evaluator. A directed table
// walks digits, all five operators, ignored codes, zero divisors, empty and
// full stacks and stack limits outside the legal range. Random expressions
// follow: mostly well-formed, some broken, some noise, with limit changes,
// idle bursts on both channels and one long output hold-off. Every result
// beat is compared field by field against a behavioral stack model or a typed row.
// ----------------------------------------------------------------------------
module tb_top;
  import pfx_eval_pkg::*;

  localparam int          STACK_DEPTH   = 16;
  localparam int          ITEM_TARGET   = 700;
  localparam int          QUIET_ITEMS   = 120;
  localparam int          HOLD_AT_ITEM  = 250;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int          MAX_REPORTS   = 10;

  typedef enum logic {ROW_BEAT, ROW_LIMIT} row_kind_t;

  typedef enum {EXPR_WELL, EXPR_BROKEN, EXPR_NOISE, EXPR_MIN_DIV, EXPR_DEEP} expr_kind_t;

  // code holds the symbol of a beat row or the limit of a limit row
  typedef struct packed {
    row_kind_t                kind;
    logic [SYM_W-1:0]         code;
    logic                     last;
    logic                     typed;
    logic signed [WORD_W-1:0] value;
    logic [2:0]               flags;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_wr_en;
  logic [LIMIT_W-1:0]   cfg_wr_data;

  // stack model
  logic signed [WORD_W-1:0] operand_mem [STACK_DEPTH];
  int unsigned              model_fill;
  logic [LIMIT_W-1:0]       model_limit;
  bit                       model_overflow;
  bit                       model_underflow;
  bit                       model_div0;

  out_beat_t  pending_results[$];
  stim_row_t  directed_rows [37];

  int  beats_sent;
  int  active_items;
  int  results_checked;
  int  limit_writes;
  int  mismatch_count;
  int  overflow_results;
  int  underflow_results;
  int  div0_results;
  bit  quiet;
  bit  hold_req;
  bit  hold_active;
  bit  hold_done;

  postfix_expression_evaluator #(
    .STACK_DEPTH (STACK_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void push_operand(input logic signed [WORD_W-1:0] v);
    int unsigned cap;
    cap = (model_limit == 0) ? 1 : ((model_limit > STACK_DEPTH) ? STACK_DEPTH : model_limit);
    if (model_fill >= cap) begin
      model_overflow = 1'b1;
    end else begin
      operand_mem[model_fill] = v;
      model_fill++;
    end
  endfunction

  function automatic logic signed [WORD_W-1:0] pop_operand();
    if (model_fill == 0) begin
      model_underflow = 1'b1;
      return EMPTY_WORD;
    end
    model_fill--;
    return operand_mem[model_fill];
  endfunction

  // advances the stack model by one beat; returns 1 when a result is due
  function automatic bit eval_symbol(input in_beat_t beat, output out_beat_t res,
                                     output bit active);
    logic signed [WORD_W-1:0] rhs;
    logic signed [WORD_W-1:0] lhs;
    logic signed [WORD_W-1:0] acc;
    longint                   wide;
    res = '0;
    active = beat.last;
    if (beat.symbol >= CHAR_0 && beat.symbol <= CHAR_9) begin
      active = 1'b1;
      push_operand(WORD_W'(beat.symbol - CHAR_0));
    end else if (beat.symbol == CHAR_MUL || beat.symbol == CHAR_DIV ||
                 beat.symbol == CHAR_ADD || beat.symbol == CHAR_SUB ||
                 beat.symbol == CHAR_MOD) begin
      active = 1'b1;
      rhs = pop_operand();
      lhs = pop_operand();
      if (beat.symbol == CHAR_ADD) begin
        acc = lhs + rhs;
      end else if (beat.symbol == CHAR_SUB) begin
        acc = lhs - rhs;
      end else if (beat.symbol == CHAR_MUL) begin
        acc = lhs * rhs;
      end else if (rhs == 0) begin
        model_div0 = 1'b1;
        acc = '0;
      end else begin
        // 64-bit math so min / -1 wraps instead of trapping
        wide = (beat.symbol == CHAR_DIV) ? longint'(lhs) / longint'(rhs)
                                         : longint'(lhs) % longint'(rhs);
        acc = wide[WORD_W-1:0];
      end
      push_operand(acc);
    end
    if (!beat.last) return 1'b0;
    if (model_fill == 0) begin
      model_underflow = 1'b1;
      res.value = EMPTY_WORD;
    end else begin
      res.value = operand_mem[model_fill-1];
    end
    res.overflow_seen       = model_overflow;
    res.underflow_seen      = model_underflow;
    res.divide_by_zero_seen = model_div0;
    model_fill      = 0;
    model_overflow  = 1'b0;
    model_underflow = 1'b0;
    model_div0      = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [SYM_W-1:0] random_digit();
    return CHAR_0 + SYM_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [SYM_W-1:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CHAR_MUL;
      1:       return CHAR_DIV;
      2:       return CHAR_ADD;
      3:       return CHAR_SUB;
      default: return CHAR_MOD;
    endcase
  endfunction

  // offers one beat until taken; typed rows replace the model's result
  task automatic send_beat(input in_beat_t beat, input bit typed, input out_beat_t known);
    out_beat_t res;
    bit        due;
    bit        active;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    due = eval_symbol(beat, res, active);
    if (due) pending_results.push_back(typed ? known : res);
    beats_sent++;
    if (active) active_items++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // an unterminated expression may still be in the divider
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] lim);
    wait_until_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model_limit = lim;
    limit_writes++;
  endtask

  task automatic send_expression(input expr_kind_t kind);
    in_beat_t script[$];
    int       pushes_left;
    int       depth;
    int       n;
    bit       terminate;
    terminate = 1'b1;
    case (kind)
      EXPR_WELL: begin
        pushes_left = $urandom_range(1, 8);
        depth = 0;
        while (pushes_left > 0 || depth > 1) begin
          if ($urandom_range(0, 9) == 0) script.push_back({8'h20, 1'b0});
          if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 1) == 1)) begin
            script.push_back({random_digit(), 1'b0});
            pushes_left--;
            depth++;
          end else begin
            script.push_back({random_operator(), 1'b0});
            depth--;
          end
        end
      end
      EXPR_BROKEN: begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0:       script.push_back({random_digit(), 1'b0});
            1:       script.push_back({random_operator(), 1'b0});
            default: script.push_back({SYM_W'($urandom_range(0, 255)), 1'b0});
          endcase
        end
      end
      EXPR_NOISE: begin
        // may leave the stack filled for the next expression
        terminate = 1'b0;
        n = $urandom_range(1, 8);
        repeat (n) script.push_back({SYM_W'($urandom_range(0, 255)),
                                     1'($urandom_range(0, 5) == 0)});
      end
      EXPR_MIN_DIV: begin
        // 8^10 * 2 wraps to the most negative word, then divide or take the remainder by 0 - 1
        script.push_back({CHAR_0 + 8'd8, 1'b0});
        repeat (9) begin
          script.push_back({CHAR_0 + 8'd8, 1'b0});
          script.push_back({CHAR_MUL, 1'b0});
        end
        script.push_back({CHAR_0 + 8'd2, 1'b0});
        script.push_back({CHAR_MUL, 1'b0});
        script.push_back({CHAR_0, 1'b0});
        script.push_back({CHAR_0 + 8'd1, 1'b0});
        script.push_back({CHAR_SUB, 1'b0});
        script.push_back({($urandom_range(0, 1) == 1) ? CHAR_DIV : CHAR_MOD, 1'b0});
      end
      default: begin
        n = $urandom_range(10, 20);
        repeat (n) script.push_back({random_digit(), 1'b0});
        repeat ($urandom_range(1, n)) script.push_back({random_operator(), 1'b0});
      end
    endcase
    if (terminate) script[$].last = 1'b1;
    foreach (script[i]) send_beat(script[i], 1'b0, '0);
  endtask

  // output side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        out_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_stall <= 1'b0;
        hold_active = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] result beat with none pending: value=%0d ovf=%b unf=%b dz=%b",
                   $time, out_data.value, out_data.overflow_seen,
                   out_data.underflow_seen, out_data.divide_by_zero_seen);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        overflow_results  += want.overflow_seen;
        underflow_results += want.underflow_seen;
        div0_results      += want.divide_by_zero_seen;
        if (out_data.value !== want.value ||
            out_data.overflow_seen !== want.overflow_seen ||
            out_data.underflow_seen !== want.underflow_seen ||
            out_data.divide_by_zero_seen !== want.divide_by_zero_seen) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: exp value=%0d ovf=%b unf=%b dz=%b,",
                     $time, want.value, want.overflow_seen, want.underflow_seen,
                     want.divide_by_zero_seen,
                     " got value=%0d ovf=%b unf=%b dz=%b",
                     out_data.value, out_data.overflow_seen,
                     out_data.underflow_seen, out_data.divide_by_zero_seen);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycles, pending_results.size());
    $display("postfix_expression_evaluator test failed");
    $finish;
  end

  initial begin : stimulus
    int r;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    model_fill      = 0;
    model_limit     = LIMIT_RST;
    model_overflow  = 1'b0;
    model_underflow = 1'b0;
    model_div0      = 1'b0;

    // kind, code, last, typed, value, {ovf, unf, dz}
    directed_rows = '{
      '{ROW_BEAT,  "9",      1'b1, 1'b1,    9, 3'b000},
      '{ROW_BEAT,  " ",      1'b1, 1'b1, -999, 3'b010},
      '{ROW_BEAT,  8'h00,    1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  8'hFF,    1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  ".",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  ":",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_0,   1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_9,   1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_SUB, 1'b1, 1'b1,   -9, 3'b000},
      '{ROW_BEAT,  "7",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_0,   1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_DIV, 1'b1, 1'b1,    0, 3'b001},
      '{ROW_BEAT,  "7",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_0,   1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_MOD, 1'b1, 1'b1,    0, 3'b001},
      '{ROW_BEAT,  "8",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "3",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_MOD, 1'b1, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "4",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "5",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_MUL, 1'b1, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_ADD, 1'b1, 1'b0,    0, 3'b000},
      '{ROW_LIMIT, 8'd1,     1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "1",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "2",      1'b1, 1'b1,    1, 3'b100},
      '{ROW_LIMIT, 8'd0,     1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "5",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "6",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_ADD, 1'b1, 1'b0,    0, 3'b000},
      '{ROW_LIMIT, 8'd16,    1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "1",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "2",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "3",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_LIMIT, 8'd2,     1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  "4",      1'b0, 1'b0,    0, 3'b000},
      '{ROW_BEAT,  CHAR_ADD, 1'b1, 1'b0,    0, 3'b000},
      '{ROW_LIMIT, 8'd31,    1'b0, 1'b0,    0, 3'b000}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_LIMIT)
        write_limit(directed_rows[i].code[LIMIT_W-1:0]);
      else
        send_beat({directed_rows[i].code, directed_rows[i].last}, directed_rows[i].typed,
                  {directed_rows[i].value, directed_rows[i].flags});
    end

    while (beats_sent < ITEM_TARGET) begin
      quiet = (beats_sent >= ITEM_TARGET - QUIET_ITEMS);
      if (!hold_done && beats_sent >= HOLD_AT_ITEM) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!hold_req && !hold_active && !quiet && $urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 6))
          0:       write_limit(5'd0);
          1:       write_limit(5'd1);
          2:       write_limit(5'd2);
          3:       write_limit(5'd16);
          4:       write_limit(5'd17);
          5:       write_limit(5'd31);
          default: write_limit(LIMIT_W'($urandom_range(0, 31)));
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 60)      send_expression(EXPR_WELL);
      else if (r < 75) send_expression(EXPR_BROKEN);
      else if (r < 85) send_expression(EXPR_NOISE);
      else if (r < 90) send_expression(EXPR_MIN_DIV);
      else             send_expression(EXPR_DEEP);
    end

    wait_until_idle();

    $display("ran %0d beats (%0d digits, operators or ends), %0d results, %0d limit writes",
             beats_sent, active_items, results_checked, limit_writes);
    $display("results flagged: %0d overflow, %0d underflow, %0d divide by zero; %0d mismatches",
             overflow_results, underflow_results, div0_results, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule
